// ===== src/uqf_pkg.sv =====
// ----------------------------------------------------------------------------
// uqf_pkg
// Shared types and constants for the unique-key fifo: operation and status
// codes, beat structs of both channels, controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package uqf_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } uqf_op_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } uqf_status_t;

  typedef struct packed {
    uqf_op_t                  op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] payload;
  } uqf_in_t;

  typedef struct packed {
    uqf_status_t              status;
    logic signed [DATA_W-1:0] out_key;
    logic signed [DATA_W-1:0] out_payload;
    logic [OCC_W-1:0]         occupancy;
  } uqf_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_rd;
    logic finish;
  } uqf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } uqf_sts_t;

endpackage

// ===== src/unique_key_fifo_top.sv =====
// ----------------------------------------------------------------------------
// unique_key_fifo_top
// Fifo of key/payload pairs that rejects an enqueue whose key is already held.
//
// Input channel: in_item (op, key, payload) is taken at a clock edge with
// start high and busy low. Each beat gives exactly one result on out_item,
// shown for one cycle with out_valid high; the receiver cannot stall, so the
// result must be taken in that cycle.
// On an enqueue the held keys are read one per cycle from the single read
// port of the key memory and compared against the new key.
// The next beat can be accepted in the cycle the result is shown.
// Reset (rst_n low, synchronous) empties the queue: head, tail and count go
// to zero and no result is pending. The memories keep their contents; only
// held entries are ever read.
// Occupancy in each result is the count after the beat, taken to 5 bits.
// ----------------------------------------------------------------------------
module unique_key_fifo_top #(
  parameter int DEPTH = uqf_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  uqf_pkg::uqf_in_t  in_item,
  output logic              out_valid,
  output uqf_pkg::uqf_out_t out_item
);
  import uqf_pkg::*;

  uqf_cmd_t cmd;
  uqf_sts_t sts;

  uqf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  uqf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== src/uqf_ctrl.sv =====
// ----------------------------------------------------------------------------
// uqf_ctrl
// Sequencer: steps the key scan over the held entries for an enqueue or reads
// the head for a dequeue, then commits the item.
module uqf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  uqf_pkg::uqf_op_t  in_op,
  input  uqf_pkg::uqf_sts_t sts,
  output uqf_pkg::uqf_cmd_t cmd,
  output logic              busy
);
  import uqf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_READ_HEAD,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_op == OP_DEQ) ? S_READ_HEAD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_READ_HEAD: begin
        cmd.scan_rd = ~sts.scan_done;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// ===== src/uqf_dp.sv =====
// ----------------------------------------------------------------------------
// uqf_dp
// Datapath: ring memories, head/tail/count, key scan compare, result register.
// ----------------------------------------------------------------------------
module uqf_dp #(
  parameter int DEPTH = uqf_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  uqf_pkg::uqf_in_t  in_item,
  input  uqf_pkg::uqf_cmd_t cmd,
  output uqf_pkg::uqf_sts_t sts,
  output logic              out_valid,
  output uqf_pkg::uqf_out_t out_item
);
  import uqf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] key_mem     [DEPTH];
  logic signed [DATA_W-1:0] payload_mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_idx_r, scan_idx_nxt;
  logic [CW-1:0] scan_left_r, scan_left_nxt;
  logic          cmp_pend_r;
  logic          dup_r, dup_nxt;
  logic          out_valid_r;
  uqf_out_t      out_r, out_nxt;

  uqf_op_t                  op_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] payload_r;
  logic signed [DATA_W-1:0] rd_key_r;
  logic signed [DATA_W-1:0] rd_payload_r;
  logic                     wr_en;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] res;
    if (idx == AW'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_item.op;
      key_r     <= in_item.key;
      payload_r <= in_item.payload;
    end
  end

  // ring memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[tail_r]     <= key_r;
      payload_mem[tail_r] <= payload_r;
    end
    if (cmd.scan_rd) begin
      rd_key_r     <= key_mem[scan_idx_r];
      rd_payload_r <= payload_mem[scan_idx_r];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    scan_left_nxt = scan_left_r;
    dup_nxt       = dup_r | (cmp_pend_r & (rd_key_r == key_r));
    wr_en         = 1'b0;
    out_nxt       = out_r;

    if (cmd.load) begin
      scan_idx_nxt  = head_r;
      scan_left_nxt = count_r;
      dup_nxt       = 1'b0;
    end else if (cmd.scan_rd) begin
      scan_idx_nxt  = wrap_inc(scan_idx_r);
      scan_left_nxt = scan_left_r - 1'b1;
    end

    if (cmd.finish) begin
      out_nxt.out_key     = '0;
      out_nxt.out_payload = '0;
      if (op_r == OP_ENQ) begin
        if (dup_r) begin
          out_nxt.status = ST_DUPLICATE;
        end else if (count_r == CW'(DEPTH)) begin
          out_nxt.status = ST_FULL;
        end else begin
          wr_en          = 1'b1;
          tail_nxt       = wrap_inc(tail_r);
          count_nxt      = count_r + 1'b1;
          out_nxt.status = ST_ENQUEUED;
        end
      end else begin
        if (count_r == '0) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          head_nxt            = wrap_inc(head_r);
          count_nxt           = count_r - 1'b1;
          out_nxt.status      = ST_DEQUEUED;
          out_nxt.out_key     = rd_key_r;
          out_nxt.out_payload = rd_payload_r;
        end
      end
      out_nxt.occupancy = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      scan_left_r <= '0;
      cmp_pend_r  <= 1'b0;
      dup_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      scan_left_r <= scan_left_nxt;
      cmp_pend_r  <= cmd.scan_rd;
      dup_r       <= dup_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign sts.scan_done = (scan_left_r == '0);
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule

// ===== bench/uqf_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uqf_checker
// Watches both channels of the unique-key fifo. Every accepted input beat
// runs through a behavioral model of the queue (ring storage, duplicate-key
// scan, full and empty rejection) and leaves its predicted result in an
// ordered store. Every result beat is compared field by field with the
// oldest prediction. Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module uqf_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  uqf_pkg::uqf_in_t  in_item,
  input  logic              out_valid,
  input  uqf_pkg::uqf_out_t out_item,
  output int                fail_count,
  output int                pending
);
  import uqf_pkg::*;

  localparam int SLOTS = DEPTH_DEF;

  logic signed [DATA_W-1:0] ring_keys [SLOTS];
  logic signed [DATA_W-1:0] ring_payloads [SLOTS];
  int head_slot;
  int tail_slot;
  int held_total;

  uqf_out_t awaited_results [$];
  uqf_out_t oldest;

  function automatic uqf_out_t predict_queue_result(uqf_in_t beat);
    uqf_out_t res;
    int slot;
    int i;
    logic dup;
    res = '0;
    dup = 1'b0;
    slot = head_slot;
    if (beat.op == OP_ENQ) begin
      for (i = 0; i < held_total; i++) begin
        if (ring_keys[slot] == beat.key) dup = 1'b1;
        slot = (slot + 1) % SLOTS;
      end
      if (dup) begin
        res.status = ST_DUPLICATE;
      end else if (held_total >= SLOTS) begin
        res.status = ST_FULL;
      end else begin
        ring_keys[tail_slot] = beat.key;
        ring_payloads[tail_slot] = beat.payload;
        tail_slot = (tail_slot + 1) % SLOTS;
        held_total++;
        res.status = ST_ENQUEUED;
      end
    end else begin
      if (held_total == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_key = ring_keys[head_slot];
        res.out_payload = ring_payloads[head_slot];
        head_slot = (head_slot + 1) % SLOTS;
        held_total--;
        res.status = ST_DEQUEUED;
      end
    end
    res.occupancy = OCC_W'(held_total);
    return res;
  endfunction

  function automatic void check_field(string field, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      held_total = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %p", $time, out_item);
          fail_count++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", DATA_W'(oldest.status), DATA_W'(out_item.status));
          check_field("out_key", oldest.out_key, out_item.out_key);
          check_field("out_payload", oldest.out_payload, out_item.out_payload);
          check_field("occupancy", DATA_W'(oldest.occupancy), DATA_W'(out_item.occupancy));
        end
      end
      if (start && !busy) awaited_results.push_back(predict_queue_result(in_item));
    end
    pending = awaited_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the unique-key fifo. A short directed run covers
// extreme keys and payloads, dequeue from empty, duplicate rejection, fill
// to full, full rejection and duplicate-before-full priority. A random run
// then mixes enqueues and dequeues in phases of changing bias so the queue
// swings between empty and full, with keys drawn often from recent enqueues
// to provoke duplicates. Sender gaps come in random bursts; three times the
// sender pauses until no result is pending. Checking is in uqf_checker.
// ----------------------------------------------------------------------------
module tb;
  import uqf_pkg::*;

  localparam int RANDOM_BEATS = 1800;
  localparam int CALM_TAIL    = 200;
  localparam int STALL_LIMIT  = 2000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  uqf_in_t  in_item;
  logic     out_valid;
  uqf_out_t out_item;
  int       fail_count;
  int       pending;
  int       quiet_cycles;

  logic signed [DATA_W-1:0] recent_keys [16];
  int recent_wr;

  unique_key_fifo_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  uqf_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(uqf_op_t op, logic [DATA_W-1:0] key, logic [DATA_W-1:0] payload);
    @(negedge clk);
    start <= 1'b1;
    in_item <= '{op: op, key: key, payload: payload};
    if (op == OP_ENQ) begin
      recent_keys[recent_wr] = key;
      recent_wr = (recent_wr + 1) % 16;
    end
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    start <= 1'b0;
    in_item <= '{op: uqf_op_t'($urandom_range(0, 1)), key: $urandom, payload: $urandom};
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_queue();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    logic [DATA_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = recent_keys[$urandom_range(0, 15)];
      4, 5, 6: begin
        k = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) k = -k;
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  initial begin
    int enq_pct;
    int idle_on;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    quiet_cycles = 0;
    recent_wr = 0;
    foreach (recent_keys[i]) recent_keys[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_beat(OP_DEQ, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OP_ENQ, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(OP_ENQ, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(OP_ENQ, 32'h0000_0000, 32'hffff_ffff);
    send_beat(OP_ENQ, 32'hffff_ffff, 32'h0000_0000);
    send_beat(OP_ENQ, 32'h8000_0000, 32'h1234_5678);
    send_beat(OP_DEQ, 32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 13; i++) send_beat(OP_ENQ, 32'h100 + i, ~i);
    send_beat(OP_ENQ, 32'h5555_aaaa, 32'haaaa_5555);
    send_beat(OP_ENQ, 32'hffff_ffff, 32'h0bad_cafe);
    drain_queue();

    // random
    enq_pct = 50;
    idle_on = 1;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 20;
          1: enq_pct = 50;
          2: enq_pct = 80;
          default: enq_pct = 95;
        endcase
        idle_on = $urandom_range(0, 1);
      end
      if (n % 600 == 300) drain_queue();
      if (idle_on && n < RANDOM_BEATS - CALM_TAIL && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 14));
      send_beat(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ, pick_key(), $urandom);
    end
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== unique_key_fifo_top.f =====
src/uqf_pkg.sv
src/uqf_ctrl.sv
src/uqf_dp.sv
src/unique_key_fifo_top.sv
bench/uqf_checker.sv
bench/tb.sv
